// ===== hdl/cbac_pkg.sv =====
// ============================================================================
// cbac_pkg: shared types and constants
// Mapper mode codes, register indexes and the configuration bundle.
// ============================================================================
package cbac_pkg;

  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned ROM_SIZE_W = 25;
  localparam int unsigned RAM_SIZE_W = 20;

  // mapper_mode codes
  localparam logic [1:0] MODE_LOW_ROM  = 2'd0;
  localparam logic [1:0] MODE_HIGH_ROM = 2'd1;
  localparam logic [1:0] MODE_COPROC   = 2'd2;
  localparam logic [1:0] MODE_PASS     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAPPER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROM_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE    = 2'd2;

  // reset values
  localparam logic [1:0]            RST_MAPPER_MODE = MODE_PASS;
  localparam logic [ROM_SIZE_W-1:0] RST_ROM_SIZE    = '0;
  localparam logic [RAM_SIZE_W-1:0] RST_RAM_SIZE    = '0;

  // bank constants
  localparam logic [7:0] WRAM_BANK = 8'h7e;

  typedef struct packed {
    logic [1:0]            mapper_mode;
    logic [ROM_SIZE_W-1:0] rom_size_bytes;
    logic [RAM_SIZE_W-1:0] ram_size_bytes;
  } cfg_t;

endpackage

// ===== hdl/cbac_cfg_regs.sv =====
// ============================================================================
// cbac_cfg_regs: configuration register file
// Three writable registers; writes to unused indexes are dropped.
// ============================================================================
module cbac_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [cbac_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [cbac_pkg::CFG_DATA_W-1:0] wr_data,
  output cbac_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mapper_mode    <= cbac_pkg::RST_MAPPER_MODE;
      cfg.rom_size_bytes <= cbac_pkg::RST_ROM_SIZE;
      cfg.ram_size_bytes <= cbac_pkg::RST_RAM_SIZE;
    end else if (wr_en) begin
      case (wr_index)
        cbac_pkg::REG_MAPPER_MODE: cfg.mapper_mode    <= wr_data[1:0];
        cbac_pkg::REG_ROM_SIZE:    cfg.rom_size_bytes <= wr_data[cbac_pkg::ROM_SIZE_W-1:0];
        cbac_pkg::REG_RAM_SIZE:    cfg.ram_size_bytes <= wr_data[cbac_pkg::RAM_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/cbac_map.sv =====
// ============================================================================
// cbac_map: address translation logic
// Combinational decode of one bank:offset address under the selected map.
// ============================================================================
module cbac_map (
  input  cbac_pkg::cfg_t                cfg,
  input  logic [cbac_pkg::ADDR_W-1:0]   addr,
  output logic [cbac_pkg::ADDR_W-1:0]   result
);

  // I/O windows return the bare offset in bank 00
  function automatic logic io_window(input logic [15:0] o, input logic coproc);
    logic hit;
    hit = (o >= 16'h2100 && o <= 16'h2183) ||
          (o >= 16'h4016 && o <= 16'h4017) ||
          (o >= 16'h4200 && o <= 16'h421f) ||
          (o >= 16'h4300 && o <= 16'h437f);
    if (coproc)
      hit = hit || (o >= 16'h2200 && o <= 16'h23ff) || (o >= 16'h3000 && o <= 16'h37ff);
    return hit;
  endfunction

  // system area below 8000: low RAM, I/O, else bank:offset
  function automatic logic [23:0] sys_map(input logic [7:0] bk, input logic [15:0] o,
                                          input logic coproc);
    if (o <= 16'h1fff)
      return {cbac_pkg::WRAM_BANK, o};
    else if (io_window(o, coproc))
      return {8'h00, o};
    else
      return {bk, o};
  endfunction

  function automatic logic [23:0] map_high(input logic [7:0] bk, input logic [15:0] o,
                                           input logic ram_en, input logic [19:0] mask);
    logic        ram_bank;
    logic [17:0] off;
    logic [7:0]  bm;
    ram_bank = (bk >= 8'h10 && bk <= 8'h3f) || (bk >= 8'h90 && bk <= 8'hbf);
    off      = {bk[4:0], o[12:0]} & mask[17:0];
    bm       = (bk <= 8'h7d) ? (bk | 8'h80) : bk;
    if (bk == 8'h7e || bk == 8'h7f)
      return {bk, o};
    else if (ram_en && ram_bank && o[15:13] == 3'b011)
      return {3'b001, off[17:13], 3'b011, off[12:0]};   // save RAM, banks 20-3f
    else if (bm <= 8'hbf && !o[15])
      return sys_map(bm, o, 1'b0);
    else
      return {2'b11, bm[5:0], o};                      // ROM in c0-ff
  endfunction

  logic [7:0]  b;
  logic [15:0] o;
  logic        wram_bank;
  logic        ram_en;
  logic [19:0] mask;
  logic        lo_keep_rom;
  logic        lo_ram_bank;
  logic        lo_fold;
  logic [18:0] lo_off;
  logic [7:0]  lo_bank;
  logic [23:0] lo_result;
  logic [23:0] hi_result;
  logic [23:0] cp_result;

  assign b         = addr[23:16];
  assign o         = addr[15:0];
  assign wram_bank = (b == 8'h7e) || (b == 8'h7f);
  assign ram_en    = (cfg.ram_size_bytes != '0);
  assign mask      = cfg.ram_size_bytes - 20'd1;

  // low-ROM
  assign lo_keep_rom = (cfg.rom_size_bytes > 25'h0200000) || (cfg.ram_size_bytes > 20'h08000);
  assign lo_ram_bank = (b >= 8'h70 && b <= 8'h7d) || (b >= 8'hf0);
  assign lo_fold     = ram_en && lo_ram_bank && (!o[15] || !lo_keep_rom);
  assign lo_off      = {b[3:0], o[14:0]} & mask[18:0];
  assign lo_bank     = b | 8'h80;

  always_comb begin
    if (wram_bank)
      lo_result = addr;
    else if (lo_fold)
      lo_result = {(b >= 8'hfe), 3'b111, lo_off[18:15], 1'b0, lo_off[14:0]};
    else if (!o[15])
      lo_result = sys_map(lo_bank, o, 1'b0);
    else
      lo_result = {lo_bank, o};
  end

  // high-ROM
  assign hi_result = map_high(b, o, ram_en, mask);

  // coprocessor
  always_comb begin
    if (b >= 8'h80 && b <= 8'hbf)
      cp_result = map_high({2'b00, b[5:0]}, o, ram_en, mask);
    else if (wram_bank)
      cp_result = addr;
    else if (ram_en && b <= 8'h3f && o[15:13] == 3'b011)
      cp_result = {8'h40, 3'b000, o[12:0]};
    else if (ram_en && b >= 8'h40 && b <= 8'h4f)
      cp_result = {b & 8'hf1, o};
    else if (b <= 8'h3f && !o[15])
      cp_result = sys_map(b, o, 1'b1);
    else
      cp_result = addr;
  end

  always_comb begin
    case (cfg.mapper_mode)
      cbac_pkg::MODE_LOW_ROM:  result = lo_result;
      cbac_pkg::MODE_HIGH_ROM: result = hi_result;
      cbac_pkg::MODE_COPROC:   result = cp_result;
      cbac_pkg::MODE_PASS:     result = addr;
      default:                 result = addr;
    endcase
  end

endmodule

// ===== hdl/cartridge_bank_address_canonicalizer.sv =====
// ============================================================================
// cartridge_bank_address_canonicalizer: cartridge address canonicalizer
// Maps a 24-bit bank:offset CPU address to its canonical address under the
// low-ROM, high-ROM or coprocessor cartridge map, or passes it through.
// ============================================================================
//
// Channel   Signals                               Handshake
// -------   -----------------------------------   ------------------------------
// item in   start, busy, cpu_address              taken when start && !busy
// item out  done, canonical_address               one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_index,      written when cfg_valid && cfg_ready
//           cfg_data
//
// Cycles: one item per clock sustained. An item taken passes through the
// input register, one level of decode logic and the result register before
// it shows on the result ports with done.
// Reset: synchronous, active high; clears the pipeline valid bits and loads
// the registers with pass-through mode and zero ROM and RAM size.
// Stalls: busy is never raised and the receiver cannot hold results off, so
// the pipeline never stops. cfg_ready is always high.
//
module cartridge_bank_address_canonicalizer (
  input  logic                            clk,
  input  logic                            rst,
  // item in
  input  logic                            start,
  output logic                            busy,
  input  logic [cbac_pkg::ADDR_W-1:0]     cpu_address,
  // item out
  output logic                            done,
  output logic [cbac_pkg::ADDR_W-1:0]     canonical_address,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbac_pkg::CFG_DATA_W-1:0] cfg_data
);

  cbac_pkg::cfg_t                cfg;
  logic                          in_valid;    // input stage holds an item
  logic [cbac_pkg::ADDR_W-1:0]   in_addr;
  logic [cbac_pkg::ADDR_W-1:0]   map_result;
  logic                          accept;

  // The decode has no state and never stalls, so both sides are always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  cbac_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage 1: capture the address.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_addr <= cpu_address;
    end
  end

  cbac_map u_map (
    .cfg    (cfg),
    .addr   (in_addr),
    .result (map_result)
  );

  // Stage 2: register the translated address and the strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      canonical_address <= map_result;
    end
  end

`ifndef ASSERT_OFF
  // every accepted item yields a strobe
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted item produced no result");

  // no strobe without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ##1 !done)
    else $error("result strobe without an accepted item");

  // work RAM banks 7e-7f pass through under every map
  a_wram_pass: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept, 2) && $past(cpu_address[23:17], 2) == 7'h3f)
      |-> canonical_address == $past(cpu_address, 2))
    else $error("work RAM address was altered");
`endif

endmodule

// ===== tb/sv/cbac_checker.sv =====
// ============================================================================
// cbac_checker: canonical address scoreboard
// Shadows the map registers, predicts each translated address on intake and
// compares it with the next result strobed out of the block.
// ============================================================================
module cbac_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [cbac_pkg::ADDR_W-1:0]     cpu_address,
  input  logic                            done,
  input  logic [cbac_pkg::ADDR_W-1:0]     canonical_address,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cbac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbac_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     mismatch_count,
  output int unsigned                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [cbac_pkg::ADDR_W-1:0] addr_t;

  localparam int unsigned WRAM_BASE = 'h7e0000;

  logic [1:0]                      map_mode  = cbac_pkg::RST_MAPPER_MODE;
  logic [cbac_pkg::ROM_SIZE_W-1:0] rom_bytes = cbac_pkg::RST_ROM_SIZE;
  logic [cbac_pkg::RAM_SIZE_W-1:0] ram_bytes = cbac_pkg::RST_RAM_SIZE;
  addr_t                           expected_addrs[$];
  int unsigned                     errors = 0;

  function automatic bit io_window(int unsigned o, bit coproc);
    return (o >= 'h2100 && o <= 'h213f) || (o >= 'h2140 && o <= 'h2183) ||
           (o >= 'h4016 && o <= 'h4017) || (o >= 'h4200 && o <= 'h421f) ||
           (o >= 'h4300 && o <= 'h437f) ||
           (coproc && ((o >= 'h2200 && o <= 'h23ff) || (o >= 'h3000 && o <= 'h37ff)));
  endfunction

  // save RAM fold mask, applied bit by bit even for odd sizes
  function automatic int unsigned fold_mask();
    int unsigned r;
    r = 32'(ram_bytes);
    return (r - 1) & 'hfffff;
  endfunction

  function automatic int unsigned high_rom_map(int unsigned b, int unsigned o);
    int unsigned fold;
    int unsigned bank;
    bank = b;
    if (b == 'h7e || b == 'h7f) return (b << 16) | o;
    if (ram_bytes != 0 && ((b >= 'h10 && b <= 'h3f) || (b >= 'h90 && b <= 'hbf)) &&
        o >= 'h6000 && o <= 'h7fff) begin
      fold = (((b & 'h1f) << 13) + (o - 'h6000)) & fold_mask();
      return (('h20 + (fold >> 13)) << 16) + 'h6000 + (fold & 'h1fff);
    end
    if (b <= 'h7d) bank = b | 'h80;
    if (bank <= 'hbf && o <= 'h7fff) begin
      if (o <= 'h1fff) return WRAM_BASE + o;
      if (io_window(o, 1'b0)) return o;
      return (bank << 16) | o;
    end
    return (('hc0 + (bank & 'h3f)) << 16) + o;
  endfunction

  function automatic addr_t canonicalize(addr_t a);
    int unsigned b;
    int unsigned o;
    int unsigned r;
    int unsigned fold;
    bit          keep_rom;
    bit          ram_bank;
    b = 32'(a[23:16]);
    o = 32'(a[15:0]);
    r = 32'(a);
    case (map_mode)
      cbac_pkg::MODE_LOW_ROM: begin
        keep_rom = rom_bytes > 'h200000 || ram_bytes > 'h8000;
        ram_bank = (b >= 'h70 && b <= 'h7d) || b >= 'hf0;
        if (b == 'h7e || b == 'h7f) r = 32'(a);
        else if (ram_bytes != 0 && ram_bank && (o <= 'h7fff || !keep_rom)) begin
          fold = (((b & 'hf) << 15) + (o & 'h7fff)) & fold_mask();
          r = (('h70 + (fold >> 15)) << 16) + (fold & 'h7fff);
          if (b >= 'hfe) r += 'h800000;
        end
        else if (o <= 'h1fff) r = WRAM_BASE + o;
        else if (o <= 'h7fff && io_window(o, 1'b0)) r = o;
        else r = ((b | 'h80) << 16) | o;
      end
      cbac_pkg::MODE_HIGH_ROM: r = high_rom_map(b, o);
      cbac_pkg::MODE_COPROC: begin
        if (b >= 'h80 && b <= 'hbf) r = high_rom_map(b - 'h80, o);
        else if (b == 'h7e || b == 'h7f) r = 32'(a);
        else if (ram_bytes != 0 && b <= 'h3f && o >= 'h6000 && o <= 'h7fff)
          r = 'h400000 + (o - 'h6000);
        else if (ram_bytes != 0 && b >= 'h40 && b <= 'h4f) r = ((b & 'hf1) << 16) + o;
        else if (b <= 'h3f && o <= 'h1fff) r = WRAM_BASE + o;
        else if (b <= 'h3f && o <= 'h7fff && io_window(o, 1'b1)) r = o;
        else r = 32'(a);
      end
      default: r = 32'(a);
    endcase
    return r[cbac_pkg::ADDR_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    addr_t want;
    if (rst) begin
      map_mode  = cbac_pkg::RST_MAPPER_MODE;
      rom_bytes = cbac_pkg::RST_ROM_SIZE;
      ram_bytes = cbac_pkg::RST_RAM_SIZE;
      expected_addrs.delete();
    end else begin
      // retire before intake: the oldest expectation is at the front
      if (done) begin
        if (expected_addrs.size() == 0) begin
          $display("%0t: unexpected result, actual %06h", $time, canonical_address);
          errors++;
        end else begin
          want = expected_addrs.pop_front();
          if (canonical_address !== want) begin
            $display("%0t: canonical_address mismatch, expected %06h, actual %06h",
                     $time, want, canonical_address);
            errors++;
          end
        end
      end
      if (start && !busy) expected_addrs.push_back(canonicalize(cpu_address));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbac_pkg::REG_MAPPER_MODE: map_mode  = cfg_data[1:0];
          cbac_pkg::REG_ROM_SIZE:    rom_bytes = cfg_data[cbac_pkg::ROM_SIZE_W-1:0];
          cbac_pkg::REG_RAM_SIZE:    ram_bytes = cfg_data[cbac_pkg::RAM_SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    pending_count  <= $unsigned(expected_addrs.size());
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top: cartridge address canonicalizer testbench
// Loads the low-ROM, high-ROM, coprocessor and pass-through maps with a range
// of ROM and save RAM sizes, streams directed and random addresses through
// the block and leaves prediction and comparison to the checker beside it.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [cbac_pkg::ADDR_W-1:0]     addr_t;
  typedef logic [cbac_pkg::CFG_IDX_W-1:0]  cfg_index_t;
  typedef logic [cbac_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [cbac_pkg::ROM_SIZE_W-1:0] rom_size_t;
  typedef logic [cbac_pkg::RAM_SIZE_W-1:0] ram_size_t;

  // index 3 has no register behind it; writes there must change nothing
  localparam cfg_index_t REG_SPARE = 2'd3;

  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned RANDOM_PHASES   = 40;
  localparam int unsigned ITEMS_PER_PHASE = 25;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       start       = 1'b0;
  addr_t      cpu_address = '0;
  logic       cfg_valid   = 1'b0;
  cfg_index_t cfg_index   = '0;
  cfg_data_t  cfg_data    = '0;
  logic       busy;
  logic       done;
  logic       cfg_ready;
  addr_t      canonical_address;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 0;   // chance in a hundred that the sender idles

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cartridge_bank_address_canonicalizer uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .cpu_address       (cpu_address),
    .done              (done),
    .canonical_address (canonical_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  cbac_checker addr_check (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .cpu_address       (cpu_address),
    .done              (done),
    .canonical_address (canonical_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  // Watchdog: any item in, result out or register write counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One item. start stays high from the previous item unless an idle gap is
  // taken, so start is never dropped and raised in the same step.
  task automatic send_item(input addr_t addr);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    start       <= 1'b1;
    cpu_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain: stop sending, wait for every expected result, then let the pipeline
  // settle. Only after this are registers touched.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Back-to-back writes: the spare index with random data first, then the
  // three map registers. cfg_valid is only dropped after the last one.
  task automatic load_map(input logic [1:0] mode,
                          input rom_size_t  rom,
                          input ram_size_t  ram);
    cfg_index_t idx [4];
    cfg_data_t  val [4];
    idx[0] = REG_SPARE;                 val[0] = cfg_data_t'($urandom);
    idx[1] = cbac_pkg::REG_MAPPER_MODE; val[1] = cfg_data_t'(mode);
    idx[2] = cbac_pkg::REG_ROM_SIZE;    val[2] = cfg_data_t'(rom);
    idx[3] = cbac_pkg::REG_RAM_SIZE;    val[3] = cfg_data_t'(ram);
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random address, mostly aimed at the bank groups and offset windows that
  // the maps tell apart; one in ten is a raw 24-bit value.
  function automatic addr_t pick_address();
    logic [7:0]  bank;
    logic [15:0] offset;
    if ($urandom_range(9) == 0) return addr_t'($urandom);
    case ($urandom_range(5))
      0:       bank = 8'($urandom_range('h3f, 'h00));   // system banks
      1:       bank = 8'($urandom_range('h4f, 'h40));   // coprocessor battery RAM
      2:       bank = 8'($urandom_range('h7f, 'h70));   // save RAM and work RAM
      3:       bank = 8'($urandom_range('hbf, 'h80));   // upper mirror of system banks
      4:       bank = 8'($urandom_range('hff, 'hc0));
      default: bank = 8'($urandom_range('hff, 'hfe));   // low-ROM fold into f0-ff
    endcase
    case ($urandom_range(7))
      0:       offset = 16'($urandom_range('h1fff, 'h0000));   // low RAM
      1:       offset = 16'($urandom_range('h2183, 'h20f0));   // PPU and APU ports
      2:       offset = 16'($urandom_range('h4400, 'h4000));   // joypad, CPU, DMA
      3:       offset = 16'($urandom_range('h37ff, 'h2190));   // coprocessor I/O
      4:       offset = 16'($urandom_range('h7fff, 'h5ff0));   // high-ROM save RAM
      5:       offset = 16'($urandom_range('hffff, 'h8000));   // ROM half
      6: begin
        case ($urandom_range(7))
          0:       offset = 16'h0000;
          1:       offset = 16'h1fff;
          2:       offset = 16'h2000;
          3:       offset = 16'h5fff;
          4:       offset = 16'h6000;
          5:       offset = 16'h7fff;
          6:       offset = 16'h8000;
          default: offset = 16'hffff;
        endcase
      end
      default: offset = 16'($urandom);
    endcase
    return {bank, offset};
  endfunction

  initial begin : stimulus
    logic [1:0] mode;
    rom_size_t  rom;
    ram_size_t  ram;
    addr_t      directed[$];

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    gap_pct = 30;

    // out of reset the map is pass-through
    directed = '{24'h000000, 24'hffffff};
    foreach (directed[i]) send_item(directed[i]);
    settle();

    // low-ROM, 4 MiB ROM: ROM mirror kept in the save RAM banks
    load_map(cbac_pkg::MODE_LOW_ROM, 25'h400000, 20'h2000);
    directed = '{24'h7e1234, 24'h001000, 24'h002100, 24'h004380,
                 24'h708000, 24'h7d1234, 24'hff7fff, 24'h00ffff};
    foreach (directed[i]) send_item(directed[i]);
    settle();

    // high-ROM, largest legal save RAM
    load_map(cbac_pkg::MODE_HIGH_ROM, 25'h0, 20'h80000);
    directed = '{24'h3f7fff, 24'h906000, 24'h400000, 24'h4f1fff,
                 24'h012140, 24'hc0ffff, 24'h7f0000};
    foreach (directed[i]) send_item(directed[i]);
    settle();

    // coprocessor map, RAM size not a power of two, largest ROM
    load_map(cbac_pkg::MODE_COPROC, 25'h1000000, 20'h3);
    directed = '{24'h2022ff, 24'h003000, 24'h206000, 24'h4f8000,
                 24'h9a6543, 24'h500000, 24'h3f8000};
    foreach (directed[i]) send_item(directed[i]);
    settle();

    // ---- random ----
    // Sender idles 30% for the first third, 59% for the second, never after.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_pct = (p < 13) ? 30 : ((p < 27) ? 59 : 0);
      case ($urandom_range(6))
        0, 1:    mode = cbac_pkg::MODE_LOW_ROM;
        2, 3:    mode = cbac_pkg::MODE_HIGH_ROM;
        4, 5:    mode = cbac_pkg::MODE_COPROC;
        default: mode = cbac_pkg::MODE_PASS;
      endcase
      case ($urandom_range(4))
        0:       rom = 25'h0;
        1:       rom = 25'h200000;      // right at the mirror threshold
        2:       rom = 25'h200001;      // just above it
        3:       rom = 25'h1000000;
        default: rom = rom_size_t'($urandom_range('h1000000, 0));
      endcase
      case ($urandom_range(7))
        0:       ram = 20'h0;
        1:       ram = 20'h8000;
        2:       ram = 20'h8001;        // keeps ROM in low-ROM, odd size
        3:       ram = 20'h80000;
        4:       ram = 20'hfffff;       // beyond 512 KiB, mask ffffe
        5, 6:    ram = ram_size_t'(1 << $urandom_range(19));
        default: ram = ram_size_t'($urandom_range('hfffff, 0));
      endcase
      if (p == 0) begin
        rom = 25'h1000000;
        ram = 20'hfffff;
      end
      load_map(mode, rom, ram);
      repeat (ITEMS_PER_PHASE) send_item(pick_address());
      settle();
    end

    repeat (5) @(posedge clk);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== cartridge_bank_address_canonicalizer.f =====
hdl/cbac_pkg.sv
hdl/cbac_cfg_regs.sv
hdl/cbac_map.sv
hdl/cartridge_bank_address_canonicalizer.sv
tb/sv/cbac_checker.sv
tb/sv/tb_top.sv
